[rtl/ovl_pkg.sv]
`timescale 1ns / 1ps

package ovl_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int VALUE_BITS_DEF = 32;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic       hit;
      logic       full_refused;
      logic [4:0] entry_count;
   } rsp_word_type;

endpackage

[rtl/ovl_mem.sv]
`timescale 1ns / 1ps

module ovl_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ovl_ctrl.sv]
`timescale 1ns / 1ps

module ovl_ctrl
   import ovl_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_data,
   output logic                       fin_valid,
   input  logic                       fin_ready,
   output rsp_word_type               fin_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic                    rmv_ff, rmv_in;
   logic [VALUE_BITS-1:0]   key_ff, key_in;
   logic                    hit_ff, hit_in;
   logic                    ref_ff, ref_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [VALUE_BITS-1:0]   wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [VALUE_BITS-1:0]   rd_data;
   logic                    match;
   logic [VALUE_BITS-1:0]   req_key;

   ovl_mem #(
      .DEPTH(DEPTH),
      .WIDTH(VALUE_BITS)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_key = VALUE_BITS'(req_data.item_value);
   assign match   = pend_ff && (rd_data == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      rmv_ff <= rmv_in;
      key_ff <= key_in;
      hit_ff <= hit_in;
      ref_ff <= ref_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      rmv_in    = rmv_ff;
      key_in    = key_ff;
      hit_in    = hit_ff;
      ref_in    = ref_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[IDX_W-1:0];
      req_ready = 1'b0;
      fin_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in  = req_key;
               rmv_in  = (req_data.req_type == KIND_REMOVE);
               hit_in  = 1'b0;
               ref_in  = 1'b0;
               ptr_in  = '0;
               pend_in = 1'b0;
               state_in = ST_FIN;
               if (req_data.req_type == KIND_APPEND) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     ref_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = req_key;
                     count_in = CNT_W'(count_ff + 1'b1);
                     hit_in   = 1'b1;
                  end
               end else if (req_data.req_type == KIND_REMOVE ||
                            req_data.req_type == KIND_QUERY) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (match) begin
               hit_in  = 1'b1;
               pend_in = 1'b0;
               if (rmv_ff) begin
                  ptr_in   = CNT_W'(pos_ff) + CNT_W'(1);
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FIN;
               end
            end else if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pos_in  = ptr_ff[IDX_W-1:0];
               ptr_in  = CNT_W'(ptr_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SHIFT: begin
            // entry at ptr moves down one slot; each write lands in the cycle after its read
            wr_en = pend_ff;
            if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pos_in  = IDX_W'(ptr_ff - 1'b1);
               ptr_in  = CNT_W'(ptr_ff + 1'b1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = CNT_W'(count_ff - 1'b1);
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            fin_valid = 1'b1;
            if (fin_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign fin_data.hit          = hit_ff;
   assign fin_data.full_refused = ref_ff;
   assign fin_data.entry_count  = 5'(count_ff);
   assign count                 = count_ff;

endmodule

[rtl/ordered_value_list.sv]
`timescale 1ns / 1ps
// Ordered value list: bounded list of up to DEPTH values, head at position 0.
// Request word (req_valid/req_ready/req_data): req_type selects append at
// tail, remove first equal entry, or membership query; item_value is the
// value. One response word (rsp_valid/rsp_ready/rsp_data) per request with
// hit, full_refused and the entry count after the request.
// An append or an unused type goes straight to the final state; a query
// scans the entry RAM, and a remove scans it and then shifts the later
// entries down, one entry a cycle. One request is in flight at a time;
// req_ready is high only when the sequencer is idle.
// A finished response sits in an output register, so the next request may
// be taken while rsp_valid waits on rsp_ready. If that register is still
// full when the next request finishes, the sequencer holds in its final
// state until rsp_ready.
// Reset (synchronous, active high) empties the list; RAM contents are left
// as they are and are never read beyond the count.
module ordered_value_list
   import ovl_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             fin_valid;
   logic             fin_ready;
   rsp_word_type     fin_data;
   logic [CNT_W-1:0] count;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_data_ff, rsp_data_in;

   ovl_ctrl #(
      .DEPTH     (DEPTH),
      .VALUE_BITS(VALUE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .fin_valid(fin_valid),
      .fin_ready(fin_ready),
      .fin_data (fin_data),
      .count    (count)
   );

   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin_valid && fin_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(DEPTH))
      else $error("list count above depth");

   a_hit_xor_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.full_refused))
      else $error("response both hit and refused");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid && !fin_ready) |=> fin_valid && $stable(fin_data))
      else $error("finished word dropped while response full");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import ovl_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   ordered_value_list u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   logic [31:0] list_vals[DEPTH];
   int unsigned list_len = 0;
   int unsigned mismatches = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;

   function automatic rsp_word_type apply_request(input req_word_type w);
      rsp_word_type r;
      int pos;
      r = '0;
      pos = -1;
      for (int i = 0; i < int'(list_len); i++)
         if (pos < 0 && list_vals[i] == w.item_value)
            pos = i;
      case (w.req_type)
         KIND_APPEND: begin
            if (list_len >= DEPTH) begin
               r.full_refused = 1'b1;
            end else begin
               list_vals[list_len] = w.item_value;
               list_len++;
               r.hit = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (pos >= 0) begin
               for (int i = pos; i + 1 < int'(list_len); i++)
                  list_vals[i] = list_vals[i + 1];
               list_len--;
               r.hit = 1'b1;
            end
         end
         KIND_QUERY: begin
            r.hit = (pos >= 0);
         end
         default: begin
         end
      endcase
      r.entry_count = list_len[4:0];
      return r;
   endfunction

   function automatic void push_word(input logic [1:0] kind, input logic [31:0] value);
      req_word_type w;
      w.req_type = kind;
      w.item_value = value;
      pending_words.insert(pending_words.size(), w);
   endfunction

   task automatic report_mismatch(input string what, input rsp_word_type want,
                                  input rsp_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: want hit=%0b refused=%0b count=%0d, got hit=%0b refused=%0b count=%0d",
                  $time, what, want.hit, want.full_refused, want.entry_count,
                  got.hit, got.full_refused, got.entry_count);
   endtask

   // segments of random words; append share shifts so the list fills and drains
   task automatic push_random_words(input int n);
      logic [31:0] pool[5];
      int append_pct;
      int r;
      logic [1:0] kind;
      logic [31:0] value;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) begin
            foreach (pool[k]) begin
               case ($urandom_range(0, 9))
                  0: pool[k] = 32'h0000_0000;
                  1: pool[k] = 32'hFFFF_FFFF;
                  default: pool[k] = $urandom();
               endcase
            end
            case ($urandom_range(0, 2))
               0: append_pct = 70;
               1: append_pct = 45;
               default: append_pct = 25;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < 3)
            kind = KIND_UNUSED;
         else if (r < 3 + append_pct)
            kind = KIND_APPEND;
         else if ($urandom_range(0, 1) == 0)
            kind = KIND_REMOVE;
         else
            kind = KIND_QUERY;
         if ($urandom_range(0, 99) < 80)
            value = pool[$urandom_range(0, 4)];
         else
            value = $urandom();
         push_word(kind, value);
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
   endtask

   // driver: bursts of random length with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp.insert(expected_rsp.size(), apply_request(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern of its own, plus one long hold-off
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_phase = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 80);
         end
         rx_mode_left--;
         rx_phase = (rx_phase + 1) % 7;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_phase >= 3);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin : monitor_proc
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.full_refused !== want.full_refused ||
                rsp_data.entry_count !== want.entry_count)
               report_mismatch("word mismatch", want, rsp_data);
         end
      end
   end

   initial begin : stimulus
      int waited;
      // directed: empty list, extremes, duplicates, full list, misses, unused type
      push_word(KIND_QUERY, 32'h0000_0000);
      push_word(KIND_REMOVE, 32'h0000_0005);
      push_word(KIND_APPEND, 32'h0000_0000);
      push_word(KIND_APPEND, 32'hFFFF_FFFF);
      push_word(KIND_APPEND, 32'h0000_0000);
      push_word(KIND_QUERY, 32'hFFFF_FFFF);
      push_word(KIND_REMOVE, 32'h0000_0000);
      push_word(KIND_QUERY, 32'h0000_0000);
      push_word(KIND_UNUSED, 32'hA5A5_A5A5);
      for (int i = 1; i <= 14; i++)
         push_word(KIND_APPEND, 32'(i));
      push_word(KIND_APPEND, 32'h5A5A_5A5A);
      push_word(KIND_REMOVE, 32'hFFFF_FFFF);
      push_word(KIND_REMOVE, 32'h0000_000E);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      @(negedge clock);
      push_random_words(700);
      hold_requests = 1;
      wait_drained();

      @(negedge clock);
      push_random_words(800);
      while (pending_words.size() > 0 || req_valid)
         @(posedge clock);
      waited = 0;
      while (expected_rsp.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("ordered_value_list verification clean");
      else
         $display("ordered_value_list verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("ordered_value_list verification failed");
      $finish;
   end

endmodule

[sim.f]
rtl/ovl_pkg.sv
rtl/ovl_mem.sv
rtl/ovl_ctrl.sv
rtl/ordered_value_list.sv
verif/tb_top.sv
